// ----- rtl/c3f_pkg.sv -----
// c3f_pkg: constants, types and register codes for the 3x3 byte filter.
// No dependencies; imported by every module of the block but the checker.
`default_nettype none

package c3f_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_BPP        = 4;
  localparam int COEF_FRAC_BITS = 8;

  localparam int COEF_W   = 12;
  localparam int NUM_TAPS = 9;
  localparam int ROW_CAP  = MAX_WIDTH * MAX_BPP;

  localparam int POS_W     = $clog2(ROW_CAP);
  localparam int LEN_W     = $clog2(ROW_CAP + 1);
  localparam int LA_W      = LEN_W + 1;
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int BPP_W     = $clog2(MAX_BPP + 1);
  localparam int WIN_N     = 3 * MAX_BPP + 1;
  localparam int WIN_IDX_W = $clog2(WIN_N);
  localparam int REC_N     = 2 * MAX_BPP;
  localparam int REC_IDX_W = $clog2(REC_N);
  localparam int MEM_DEPTH = 3 * (2 ** POS_W);
  localparam int MEM_AW    = POS_W + 2;

  localparam int PROD_W = COEF_W + 9;
  localparam int SUM_W  = PROD_W + 4;

  localparam int QDEPTH  = 4;
  localparam int Q_PTR_W = $clog2(QDEPTH);
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);

  localparam int BYTE_MAX = 255;

  // configuration port
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KERN_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KERN_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BPP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd4;

  localparam logic MODE_CLAMP = 1'b0;
  localparam logic MODE_ABS   = 1'b1;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_PAD  = 1'b1;

  typedef logic [7:0] byte_t;
  typedef logic [NUM_TAPS-1:0][7:0] taps_t;
  typedef logic [NUM_TAPS-1:0][COEF_W-1:0] coef_vec_t;

  typedef struct packed {
    taps_t taps;
    logic  last;
  } job_t;

  typedef struct packed {
    logic [1:0] cnt;
    job_t       first;
    job_t       second;
  } push_t;

  typedef struct packed {
    logic [BPP_W-1:0] stride;
    logic [LEN_W-1:0] len;
  } geo_t;

endpackage

`default_nettype wire

// ----- rtl/c3f_cfg.sv -----
// c3f_cfg: APB register file, weight unpacking and row geometry clamping.
// Depends on c3f_pkg.
`default_nettype none

module c3f_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [c3f_pkg::CFG_AW-1:0] paddr,
  input  wire logic [c3f_pkg::CFG_DW-1:0] pwdata,
  output logic      [c3f_pkg::CFG_DW-1:0] prdata,
  output logic                           pready,
  output c3f_pkg::coef_vec_t             coefs,
  output c3f_pkg::geo_t                  geo,
  output logic                           mode,
  output logic                           cfg_wr
);
  import c3f_pkg::*;

  logic [59:0]          kern_a_r;
  logic [47:0]          kern_b_r;
  logic [10:0]          width_r;
  logic [2:0]           bpp_r;
  logic                 mode_r;
  logic [REG_IDX_W-1:0] idx;
  logic [WID_W-1:0]     w;
  logic [BPP_W-1:0]     b;

  assign idx    = paddr[CFG_AW-1:3];
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign mode   = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_a_r <= '0;
      kern_b_r <= '0;
      width_r  <= 11'd3;
      bpp_r    <= 3'd3;
      mode_r   <= MODE_CLAMP;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_KERN_A: kern_a_r <= pwdata[59:0];
        REG_KERN_B: kern_b_r <= pwdata[47:0];
        REG_WIDTH:  width_r  <= pwdata[10:0];
        REG_BPP:    bpp_r    <= pwdata[2:0];
        REG_MODE:   mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KERN_A: prdata = {4'd0, kern_a_r};
      REG_KERN_B: prdata = {16'd0, kern_b_r};
      REG_WIDTH:  prdata = {53'd0, width_r};
      REG_BPP:    prdata = {61'd0, bpp_r};
      REG_MODE:   prdata = {63'd0, mode_r};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (i < 5) coefs[i] = kern_a_r[COEF_W*i +: COEF_W];
      else       coefs[i] = kern_b_r[COEF_W*(i-5) +: COEF_W];
    end
  end

  // geometry used clamped to its legal range
  always_comb begin
    if (32'(width_r) < 3)              w = WID_W'(3);
    else if (32'(width_r) > MAX_WIDTH) w = WID_W'(MAX_WIDTH);
    else                               w = WID_W'(width_r);
    if (32'(bpp_r) < 3)                b = BPP_W'(3);
    else if (32'(bpp_r) > MAX_BPP)     b = BPP_W'(MAX_BPP);
    else                               b = BPP_W'(bpp_r);
    geo.stride = b;
    geo.len    = LEN_W'(w) * LEN_W'(b);
  end

endmodule

`default_nettype wire

// ----- rtl/c3f_front.sv -----
// c3f_front: position/row tracking, row store, tap windows and job building.
// Depends on c3f_pkg. Pushes zero to two kernel jobs per accepted beat.
`default_nettype none

module c3f_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_op,
  input  wire logic [7:0]    in_pixel_byte,
  input  wire c3f_pkg::geo_t geo,
  input  wire logic          cfg_wr,
  input  wire logic          room,
  output c3f_pkg::push_t     push
);
  import c3f_pkg::*;

  function automatic logic [1:0] slot_back(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_fwd(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  // control
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       rot_r, rot_nxt;
  logic [1:0]       rows_r, rows_nxt;
  logic [REC_N-1:0][7:0] rec_r, rec_nxt;
  logic             fresh_r;

  // row store and windows
  byte_t mem [MEM_DEPTH];
  byte_t rd_a_r, rd_b_r;
  logic [MEM_AW-1:0] addr_a, addr_b;
  logic [WIN_N-2:0][7:0] wa_r, wb_r;
  logic [WIN_N-1:0][7:0] wa_full, wb_full, etop_r, emid_r;

  logic [LEN_W-1:0] len, b_l, p_l;
  logic [POS_W-1:0] p, p_n;
  logic [LA_W-1:0]  la;
  logic             acc, is_pad, row_end;
  byte_t            byte_in;
  logic             rs1, rs2, rs3, p_lt_b, p_ge_2b, pb_in, do1, do2;
  logic [WIN_IDX_W-1:0] ib, i2b, i3b, plo, e1, e2;
  logic [REC_IDX_W-1:0] r2b1, rb1;
  job_t             wrap_job, main_job;

  assign len      = geo.len;
  assign b_l      = LEN_W'(geo.stride);
  assign in_ready = fresh_r && room;
  assign acc      = in_valid && in_ready;
  assign is_pad   = (in_op == OP_PAD);
  assign byte_in  = is_pad ? 8'd0 : in_pixel_byte;
  assign p        = (LEN_W'(pos_r) < len) ? pos_r : POS_W'(len - LEN_W'(1));
  assign p_l      = LEN_W'(p);
  assign row_end  = (LA_W'(p_l) + LA_W'(1)) >= LA_W'(len);
  assign wa_full  = {wa_r, rd_a_r};
  assign wb_full  = {wb_r, rd_b_r};

  always_comb begin
    pos_nxt  = pos_r;
    rot_nxt  = rot_r;
    rows_nxt = rows_r;
    rec_nxt  = rec_r;
    if (acc) begin
      rec_nxt = {rec_r[REC_N-2:0], byte_in};
      if (row_end) begin
        pos_nxt = '0;
        if (is_pad) begin
          rot_nxt  = 2'd0;
          rows_nxt = 2'd0;
          rec_nxt  = '0;
        end else begin
          rot_nxt  = slot_fwd(rot_r);
          rows_nxt = (rows_r == 2'd3) ? 2'd3 : rows_r + 2'd1;
        end
      end else begin
        pos_nxt = p + POS_W'(1);
      end
    end
  end

  // prefetch one byte per stored row, stride ahead of the next beat;
  // near row end it fetches the start of the rows the next row needs
  always_comb begin
    p_n = (LEN_W'(pos_nxt) < len) ? pos_nxt : POS_W'(len - LEN_W'(1));
    la  = LA_W'(p_n) + LA_W'(geo.stride);
    if (la < LA_W'(len)) begin
      addr_a = {slot_fwd(rot_nxt), POS_W'(la)};
      addr_b = {slot_back(rot_nxt), POS_W'(la)};
    end else begin
      addr_a = {slot_back(rot_nxt), POS_W'(la - LA_W'(len))};
      addr_b = {rot_nxt, POS_W'(la - LA_W'(len))};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) mem[{rot_r, p}] <= byte_in;
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      rot_r   <= 2'd0;
      rows_r  <= 2'd0;
      rec_r   <= '0;
      fresh_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      rot_r   <= rot_nxt;
      rows_r  <= rows_nxt;
      rec_r   <= rec_nxt;
      fresh_r <= !cfg_wr;   // prefetch address moves with geometry
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      wa_r <= wa_full[WIN_N-2:0];
      wb_r <= wb_full[WIN_N-2:0];
      if (row_end && !is_pad) begin
        etop_r <= wa_full;
        emid_r <= wb_full;
      end
    end
  end

  // window offsets: entry 0 is the byte stride ahead of the current beat
  always_comb begin
    ib   = WIN_IDX_W'(geo.stride);
    i2b  = ib << 1;
    i3b  = ib + i2b;
    plo  = WIN_IDX_W'(p);
    e1   = i3b - WIN_IDX_W'(1) - plo;
    e2   = i2b - WIN_IDX_W'(1) - plo;
    r2b1 = REC_IDX_W'(i2b - WIN_IDX_W'(1));
    rb1  = REC_IDX_W'(ib - WIN_IDX_W'(1));
  end

  always_comb begin
    rs1     = (rows_r != 2'd0);
    rs2     = (rows_r >= 2'd2);
    rs3     = (rows_r == 2'd3);
    p_lt_b  = p_l < b_l;
    p_ge_2b = p_l >= (b_l << 1);
    pb_in   = (LA_W'(p_l) + LA_W'(b_l)) < LA_W'(len);
    do1     = p_lt_b && rs2;
    do2     = rs1 && (is_pad || !p_lt_b);

    // tail of the row two back, finished at the start of this row
    wrap_job.taps[0] = rs3 ? etop_r[e1] : 8'd0;
    wrap_job.taps[1] = rs3 ? etop_r[e2] : 8'd0;
    wrap_job.taps[2] = 8'd0;
    wrap_job.taps[3] = emid_r[e1];
    wrap_job.taps[4] = emid_r[e2];
    wrap_job.taps[5] = 8'd0;
    wrap_job.taps[6] = rec_r[r2b1];
    wrap_job.taps[7] = rec_r[rb1];
    wrap_job.taps[8] = 8'd0;
    wrap_job.last    = !do2;

    if (is_pad) begin
      main_job.taps[0] = (rs2 && !p_lt_b) ? wa_full[i2b] : 8'd0;
      main_job.taps[1] = rs2 ? wa_full[ib] : 8'd0;
      main_job.taps[2] = (rs2 && pb_in) ? wa_full[0] : 8'd0;
      main_job.taps[3] = !p_lt_b ? wb_full[i2b] : 8'd0;
      main_job.taps[4] = wb_full[ib];
      main_job.taps[5] = pb_in ? wb_full[0] : 8'd0;
      main_job.taps[6] = 8'd0;
      main_job.taps[7] = 8'd0;
      main_job.taps[8] = 8'd0;
    end else begin
      main_job.taps[0] = (rs2 && p_ge_2b) ? wa_full[i3b] : 8'd0;
      main_job.taps[1] = rs2 ? wa_full[i2b] : 8'd0;
      main_job.taps[2] = rs2 ? wa_full[ib] : 8'd0;
      main_job.taps[3] = p_ge_2b ? wb_full[i3b] : 8'd0;
      main_job.taps[4] = wb_full[i2b];
      main_job.taps[5] = wb_full[ib];
      main_job.taps[6] = p_ge_2b ? rec_r[r2b1] : 8'd0;
      main_job.taps[7] = rec_r[rb1];
      main_job.taps[8] = byte_in;
    end
    main_job.last = 1'b1;

    push.cnt    = acc ? ({1'b0, do1} + {1'b0, do2}) : 2'd0;
    push.first  = do1 ? wrap_job : main_job;
    push.second = main_job;
  end

endmodule

`default_nettype wire

// ----- rtl/c3f_queue.sv -----
// c3f_queue: short job queue between front and kernel datapath.
// Depends on c3f_pkg. Takes up to two jobs per cycle, hands out one when the datapath takes it.
`default_nettype none

module c3f_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire c3f_pkg::push_t push,
  output logic                room,
  output logic                head_valid,
  output c3f_pkg::job_t       head,
  input  wire logic           take
);
  import c3f_pkg::*;

  job_t               q_r [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               pop;

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign pop        = head_valid && take;
  assign room       = cnt_r <= Q_CNT_W'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) q_r[wr_ptr_r + Q_PTR_W'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(push.cnt);
      if (pop) rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      cnt_r <= cnt_r + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c3f_back.sv -----
// c3f_back: kernel datapath - products, partial sums, rounding and limiting,
// output register. Depends on c3f_pkg.
`default_nettype none

module c3f_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire c3f_pkg::job_t      head,
  output logic                    take,
  input  wire c3f_pkg::coef_vec_t coefs,
  input  wire logic               mode,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last
);
  import c3f_pkg::*;

  logic                     s1_v_r, s1_last_r;
  logic signed [PROD_W-1:0] s1_prod_r [NUM_TAPS];
  logic                     s2_v_r, s2_last_r;
  logic signed [SUM_W-1:0]  s2_sum_r [3];
  logic                     out_v_r, out_last_r;
  byte_t                    out_byte_r;

  logic                     out_free, s2_free, s1_free;
  logic signed [SUM_W-1:0]  total;
  logic [SUM_W-1:0]         mag, shv;
  logic                     neg;
  byte_t                    res;

  assign out_free  = !out_v_r || out_ready;
  assign s2_free   = !s2_v_r || out_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign take      = s1_free;
  assign out_valid = out_v_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // exact sum, magnitude truncated toward zero
  always_comb begin
    total = s2_sum_r[0] + s2_sum_r[1] + s2_sum_r[2];
    neg   = total[SUM_W-1];
    mag   = neg ? SUM_W'(-total) : SUM_W'(total);
    shv   = mag >> COEF_FRAC_BITS;
    if (neg && mode == MODE_CLAMP)      res = 8'd0;
    else if (shv > SUM_W'(BYTE_MAX))    res = 8'(BYTE_MAX);
    else                                res = shv[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r  <= head_valid;
      if (s2_free)  s2_v_r  <= s1_v_r;
      if (out_free) out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && head_valid) begin
      for (int i = 0; i < NUM_TAPS; i++)
        s1_prod_r[i] <= $signed(coefs[i]) * $signed({1'b0, head.taps[i]});
      s1_last_r <= head.last;
    end
    if (s2_free && s1_v_r) begin
      for (int g = 0; g < 3; g++)
        s2_sum_r[g] <= SUM_W'(s1_prod_r[3*g]) + SUM_W'(s1_prod_r[3*g+1])
                     + SUM_W'(s1_prod_r[3*g+2]);
      s2_last_r <= s1_last_r;
    end
    if (out_free && s2_v_r) begin
      out_byte_r <= res;
      out_last_r <= s2_last_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/conv3x3_byte_filter.sv -----
// Streaming 3x3 byte convolution with zero borders: top level.
// Depends on c3f_pkg, c3f_cfg, c3f_front, c3f_queue, c3f_back.
//
// Takes one image byte per cycle in raster order while in_ready is high and
// returns the filtered bytes of the row above while the current row arrives;
// after the last row send one padding beat per byte of the zero row below to
// drain the image and end the pass. A beat normally yields at most one result,
// so the block sustains one byte per clock unless the output stalls; padding
// beats at the first pixel of the padding row yield two results each. The
// input stalls in the cycle after each register write while the row-store
// prefetch re-aims. Results pass through the job queue and the product,
// partial-sum and output registers. The row store (3 rows of MAX_WIDTH*MAX_BPP
// bytes) is one memory, one write and two reads per cycle, not cleared by reset.
`default_nettype none

module conv3x3_byte_filter (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_op,
  input  wire logic [7:0]                 in_pixel_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      out_out_byte,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [c3f_pkg::CFG_AW-1:0] paddr,
  input  wire logic [c3f_pkg::CFG_DW-1:0] pwdata,
  output logic      [c3f_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);
  import c3f_pkg::*;

  coef_vec_t coefs;
  geo_t      geo;
  logic      mode, cfg_wr, room, head_valid, take;
  push_t     push;
  job_t      head;

  c3f_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs),
    .geo     (geo),
    .mode    (mode),
    .cfg_wr  (cfg_wr)
  );

  c3f_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_pixel_byte (in_pixel_byte),
    .geo           (geo),
    .cfg_wr        (cfg_wr),
    .room          (room),
    .push          (push)
  );

  c3f_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  c3f_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .coefs      (coefs),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_out_byte),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

// ----- rtl/c3f_checker.sv -----
// c3f_checker: port-level assertions for conv3x3_byte_filter, with bind.
// Depends on nothing but the top level's port names.
`default_nettype none

module c3f_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_out_byte,
  input wire logic       out_last,
  input wire logic       psel,
  input wire logic       penable,
  input wire logic       pwrite,
  input wire logic       pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_byte) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // prefetch must re-aim after geometry may have changed
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> !in_ready)
    else $error("input ready in cycle after register write");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind conv3x3_byte_filter c3f_checker u_c3f_checker (.*);

`default_nettype wire

// ----- tb/conv3x3_byte_filter_tb.sv -----
// Self-checking testbench for conv3x3_byte_filter: streams image passes with
// random geometry and kernels, predicts every filtered byte and checks it.
// Depends on c3f_pkg and the conv3x3_byte_filter RTL.
`default_nettype none

module conv3x3_byte_filter_tb;
  import c3f_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam int ROWBYTES = MAX_WIDTH * MAX_BPP;

  typedef struct {
    logic       op;
    logic [7:0] pix;
  } beat_t;

  typedef struct {
    logic [7:0] val;
    logic       last;
  } filt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_op = 1'b0;
  logic [7:0] in_pixel_byte = 8'd0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  wire logic in_ready;
  wire logic out_valid;
  wire logic [7:0] out_out_byte;
  wire logic out_last;
  wire logic [CFG_DW-1:0] prdata;
  wire logic pready;

  conv3x3_byte_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_pixel_byte(in_pixel_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_out_byte(out_out_byte),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  beat_t pending[$];
  filt_t expected[$];
  int fails = 0;
  int cycles = 0;
  bit steady = 1'b0;

  // shadow of the block's registers and line buffers
  logic [59:0] kern_a = '0;
  logic [47:0] kern_b = '0;
  logic [10:0] width_reg = 11'd3;
  logic [2:0]  bpp_reg = 3'd3;
  logic        mode_reg = MODE_CLAMP;
  logic [7:0]  rows_mem [3][ROWBYTES];
  int rot = 0;
  int bpos = 0;
  int seen = 0;
  logic [63:0] recent = '0;
  int win [9];

  function automatic int stride_eff();
    return (bpp_reg < 3) ? 3 : (bpp_reg > MAX_BPP) ? MAX_BPP : int'(bpp_reg);
  endfunction

  function automatic int row_len();
    int w;
    w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    return w * stride_eff();
  endfunction

  function automatic longint weight(int i);
    logic [11:0] raw;
    raw = (i < 5) ? kern_a[12*i +: 12] : kern_b[12*(i-5) +: 12];
    return longint'($signed(raw));
  endfunction

  function automatic logic [7:0] weigh();
    longint s;
    longint mag;
    s = 0;
    for (int i = 0; i < 9; i++) s += weight(i) * longint'(win[i]);
    mag = (s < 0) ? -s : s;
    mag = mag >>> COEF_FRAC_BITS;
    if (s < 0 && mode_reg == MODE_CLAMP) return 8'd0;
    return (mag > BYTE_MAX) ? 8'd255 : mag[7:0];
  endfunction

  function automatic int px(int slot, bit ok, int c, int len);
    return (ok && c >= 0 && c < len) ? int'(rows_mem[slot][c]) : 0;
  endfunction

  function automatic void fill(int at, int slot, bit ok, int c, int b, int len);
    win[at] = px(slot, ok, c - b, len);
    win[at+1] = px(slot, ok, c, len);
    win[at+2] = px(slot, ok, c + b, len);
  endfunction

  task automatic filter_beat(input logic op, input logic [7:0] pix);
    bit pad;
    logic [7:0] byt;
    int b, len, p, cur, prev1, prev2, n, c, q;
    filt_t res [2];
    pad = (op == OP_PAD);
    byt = pad ? 8'd0 : pix;
    b = stride_eff();
    len = row_len();
    p = (bpos < len) ? bpos : len - 1;
    cur = rot % 3;
    prev1 = (cur + 2) % 3;
    prev2 = (cur + 1) % 3;
    n = 0;
    // wrap-around: first bytes of a row finish the right edge two rows up
    if (p < b && seen >= 2) begin
      q = len - b + p;
      fill(0, cur, seen >= 3, q, b, len);
      fill(3, prev2, 1'b1, q, b, len);
      fill(6, prev1, 1'b1, q, b, len);
      res[n].val = weigh(); res[n].last = 1'b0; n++;
    end
    if (seen >= 1) begin
      if (pad) begin
        fill(0, prev2, seen >= 2, p, b, len);
        fill(3, prev1, 1'b1, p, b, len);
        win[6] = 0; win[7] = 0; win[8] = 0;
        res[n].val = weigh(); res[n].last = 1'b0; n++;
      end else if (p >= b) begin
        c = p - b;
        fill(0, prev2, seen >= 2, c, b, len);
        fill(3, prev1, 1'b1, c, b, len);
        win[6] = (c >= b) ? int'(recent[8*(2*b-1) +: 8]) : 0;
        win[7] = int'(recent[8*(b-1) +: 8]);
        win[8] = int'(byt);
        res[n].val = weigh(); res[n].last = 1'b0; n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected.push_back(res[i]);
    rows_mem[cur][p] = byt;
    recent = {recent[55:0], byt};
    if (p + 1 >= len) begin
      bpos = 0;
      if (pad) begin
        rot = 0; seen = 0; recent = '0;
      end else begin
        rot = (cur + 1) % 3;
        if (seen < 3) seen++;
      end
    end else begin
      bpos = p + 1;
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    fails++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending.size() > 0 && (steady || $urandom_range(99) >= 27)) begin
        in_valid <= 1'b1;
        in_op <= pending[0].op;
        in_pixel_byte <= pending[0].pix;
        void'(pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 27);
  end

  // prediction and check
  always @(posedge clk) begin
    filt_t e;
    if (rst_n) begin
      if (in_valid && in_ready) filter_beat(in_op, in_pixel_byte);
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          report("unexpected beat", out_out_byte, -1);
        end else begin
          e = expected.pop_front();
          if (out_out_byte !== e.val) report("out_byte", out_out_byte, e.val);
          if (out_last !== e.last) report("last", out_last, e.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("conv3x3_byte_filter test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 3; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_KERN_A: kern_a = v[59:0];
      REG_KERN_B: kern_b = v[47:0];
      REG_WIDTH:  width_reg = v[10:0];
      REG_BPP:    bpp_reg = v[2:0];
      REG_MODE:   mode_reg = v[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [107:0] rand_kernel(bit full);
    logic [107:0] k;
    int w;
    for (int i = 0; i < 9; i++) begin
      w = full ? int'($urandom_range(4095)) : int'($urandom_range(511)) - 256;
      k[12*i +: 12] = w[11:0];
    end
    return k;
  endfunction

  // one pass: image rows (with stray padding beats) then the zero row below
  task automatic queue_pass(input int rows, input int noise, input bit extremes);
    beat_t bt;
    int len;
    len = row_len();
    for (int r = 0; r < rows; r++)
      for (int p = 0; p < len; p++) begin
        bt.op = (p != len - 1 && $urandom_range(99) < noise) ? OP_PAD : OP_DATA;
        bt.pix = extremes ? ((p % 2) ? 8'hFF : 8'h00) : 8'($urandom);
        pending.push_back(bt);
      end
    for (int p = 0; p < len; p++) begin
      bt.op = OP_PAD;
      bt.pix = 8'($urandom);
      pending.push_back(bt);
    end
  endtask

  initial begin
    logic [107:0] k;
    int sent;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: padding with no image, identity kernel on 0/255, then all-min weights
    write_reg(REG_KERN_A, 64'h0100_0000_0000_0000);
    write_reg(REG_KERN_B, 64'h0);
    queue_pass(0, 0, 1'b0);
    drain();
    queue_pass(1, 0, 1'b1);
    drain();
    write_reg(REG_KERN_A, 64'h0800_8008_0080_0800);
    write_reg(REG_KERN_B, 64'h8008_0080_0800);
    write_reg(REG_MODE, 64'(MODE_ABS));
    queue_pass(1, 0, 1'b1);
    drain();

    for (int ph = 0; sent < 700; ph++) begin
      k = rand_kernel($urandom_range(3) == 0);
      write_reg(REG_KERN_A, {4'h0, k[59:0]});
      write_reg(REG_KERN_B, {16'h0, k[107:60]});
      write_reg(REG_WIDTH, ($urandom_range(9) == 0) ? 64'($urandom_range(40))
                                                    : 64'($urandom_range(6)));
      write_reg(REG_BPP, 64'($urandom_range(7)));
      write_reg(REG_MODE, 64'($urandom_range(1)));
      steady = (ph == 4);
      queue_pass($urandom_range(4), ($urandom_range(3) == 0) ? 10 : 0, 1'b0);
      sent += pending.size();
      drain();
      steady = 1'b0;
    end

    if (fails == 0) begin
      $display("conv3x3_byte_filter test passed");
    end else begin
      $display("conv3x3_byte_filter test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/c3f_pkg.sv
rtl/c3f_cfg.sv
rtl/c3f_front.sv
rtl/c3f_queue.sv
rtl/c3f_back.sv
rtl/conv3x3_byte_filter.sv
rtl/c3f_checker.sv
tb/conv3x3_byte_filter_tb.sv
